@@ sv/fcb_pkg.sv @@
// ----------------------------------------------------------------------------
// fcb_pkg
// Shared types, constants and plane tables for the frustum box cull block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fcb_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int ELEM_W        = 32;
	localparam int PLANE_W       = ELEM_W + 1;
	localparam int PLANE_COUNT   = 6;
	localparam int PLANE_ENTRIES = PLANE_COUNT * 4;
	localparam int PL_ADDR_W     = 5;
	// split point of the wide plane sums for the shared multiplier
	localparam int Q_SPLIT       = 34;

	typedef enum logic [1:0] {
		CMD_VIEW = 2'd0,
		CMD_OBJ  = 2'd1,
		CMD_TEST = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		P_IDLE,
		P_RD,
		P_CAP,
		P_WR
	} pstate_t;

	typedef enum logic [3:0] {
		T_IDLE,
		T_PRD,
		T_PCAP,
		T_QRD,
		T_QMUL,
		T_QACC,
		T_CINIT,
		T_CMUL,
		T_CACC,
		T_CSUM,
		T_CDEC,
		T_DONE
	} tstate_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] min_x;
		logic signed [ELEM_W-1:0] min_y;
		logic signed [ELEM_W-1:0] min_z;
		logic signed [ELEM_W-1:0] max_x;
		logic signed [ELEM_W-1:0] max_y;
		logic signed [ELEM_W-1:0] max_z;
	} box_t;

	// view row combined with the w row: left, right, top, bottom, back, front
	function automatic logic [1:0] plane_row(input logic [2:0] k);
		logic [1:0] r;
		begin
			unique case (k)
				3'd0, 3'd1: r = 2'd0;
				3'd2, 3'd3: r = 2'd1;
				default:    r = 2'd2;
			endcase
			return r;
		end
	endfunction

	function automatic logic plane_adds(input logic [2:0] k);
		logic a;
		begin
			unique case (k)
				3'd0, 3'd3, 3'd4: a = 1'b1;
				default:          a = 1'b0;
			endcase
			return a;
		end
	endfunction

endpackage

@@ sv/fcb_ifs.sv @@
// ----------------------------------------------------------------------------
// fcb_ifs
// Valid/ready channel interfaces for command words and cull results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fcb_item_if;
	logic                valid;
	logic                ready;
	logic [1:0]          command;
	logic [3:0]          elem_index;
	logic signed [31:0]  elem_value;
	logic signed [31:0]  box_min_x;
	logic signed [31:0]  box_min_y;
	logic signed [31:0]  box_min_z;
	logic signed [31:0]  box_max_x;
	logic signed [31:0]  box_max_y;
	logic signed [31:0]  box_max_z;

	modport source (output valid, command, elem_index, elem_value, box_min_x, box_min_y,
		box_min_z, box_max_x, box_max_y, box_max_z, input ready);
	modport sink (input valid, command, elem_index, elem_value, box_min_x, box_min_y,
		box_min_z, box_max_x, box_max_y, box_max_z, output ready);
endinterface

interface fcb_result_if;
	logic valid;
	logic ready;
	logic visible;

	modport source (output valid, visible, input ready);
	modport sink (input valid, visible, output ready);
endinterface

@@ sv/fcb_plane_unit.sv @@
// ----------------------------------------------------------------------------
// fcb_plane_unit
// View matrix memory and clip plane memory; rebuilds the six planes of one
// column after each view element write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcb_plane_unit import fcb_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [3:0]                 wr_idx,
	input  logic [ELEM_W-1:0]          wr_val,
	input  logic [PL_ADDR_W-1:0]       rd_addr,
	output logic signed [PLANE_W-1:0]  rd_data,
	output logic                       idle
);

	pstate_t state_q, state_nxt;

	logic [ELEM_W-1:0]  vmem [16];
	logic [15:0]        vvld_q;
	logic [ELEM_W-1:0]  vraw_s1;
	logic               vvld_s1;
	logic               rdv_s1;
	logic [1:0]         ridx_s1;
	logic [ELEM_W-1:0]  vcol_q [4];
	logic [1:0]         col_q;
	logic [2:0]         cnt_q;
	logic [3:0]         vrd_addr;

	logic [PLANE_W-1:0] pmem [PLANE_ENTRIES];
	logic [PLANE_ENTRIES-1:0] pvld_q;
	logic [PLANE_W-1:0] praw_s1;
	logic               pvld_s1;
	logic               pm_we;
	logic [PL_ADDR_W-1:0] pm_addr;
	logic signed [PLANE_W-1:0] w_ext, e_ext, pval;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			P_IDLE: if (wr_en) state_nxt = P_RD;
			P_RD:   if (cnt_q == 3'd3) state_nxt = P_CAP;
			P_CAP:  state_nxt = P_WR;
			P_WR:   if (cnt_q == 3'(PLANE_COUNT - 1)) state_nxt = P_IDLE;
			default: state_nxt = P_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		idle     = (state_q == P_IDLE);
		pm_we    = (state_q == P_WR);
		vrd_addr = {col_q, cnt_q[1:0]};
		pm_addr  = {cnt_q, col_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
			col_q   <= '0;
			cnt_q   <= '0;
			rdv_s1  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			rdv_s1  <= (state_q == P_RD);
			if (state_q == P_IDLE && wr_en) begin
				col_q <= wr_idx[3:2];
				cnt_q <= '0;
			end else if (state_q == P_RD) begin
				cnt_q <= (cnt_q == 3'd3) ? 3'd0 : cnt_q + 3'd1;
			end else if (state_q == P_WR) begin
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	// view memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (wr_en) vmem[wr_idx] <= wr_val;
		vraw_s1 <= vmem[vrd_addr];
		ridx_s1 <= cnt_q[1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vvld_q  <= '0;
			vvld_s1 <= 1'b0;
		end else begin
			if (wr_en) vvld_q[wr_idx] <= 1'b1;
			vvld_s1 <= vvld_q[vrd_addr];
		end
	end

	// capture the column being rebuilt
	always_ff @(posedge clk) begin
		if (rdv_s1) vcol_q[ridx_s1] <= vvld_s1 ? vraw_s1 : '0;
	end

	// plane component: w row plus or minus the selected row
	always_comb begin
		w_ext = PLANE_W'(signed'(vcol_q[3]));
		e_ext = PLANE_W'(signed'(vcol_q[plane_row(cnt_q)]));
		pval  = plane_adds(cnt_q) ? w_ext + e_ext : w_ext - e_ext;
	end

	// plane memory
	always_ff @(posedge clk) begin
		if (pm_we) pmem[pm_addr] <= pval;
		praw_s1 <= pmem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvld_q  <= '0;
			pvld_s1 <= 1'b0;
		end else begin
			if (pm_we) pvld_q[pm_addr] <= 1'b1;
			pvld_s1 <= pvld_q[rd_addr];
		end
	end

	assign rd_data = pvld_s1 ? signed'(praw_s1) : '0;

endmodule

@@ sv/fcb_test_unit.sv @@
// ----------------------------------------------------------------------------
// fcb_test_unit
// Object matrix memory and the box test sequencer around one shared
// signed multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcb_test_unit import fcb_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  box_t                       box,
	input  logic                       obj_we,
	input  logic [3:0]                 obj_idx,
	input  logic [ELEM_W-1:0]          obj_val,
	output logic [PL_ADDR_W-1:0]       pl_addr,
	input  logic signed [PLANE_W-1:0]  pl_data,
	output logic                       res_valid,
	output logic                       res_visible,
	input  logic                       res_ready,
	output logic                       idle
);

	localparam int MA_W = PLANE_W;
	localparam int MB_W = Q_SPLIT + 1;
	localparam int P_W  = MA_W + MB_W;
	localparam int Q_W  = PLANE_W + ELEM_W + 2;
	localparam int T_W  = ELEM_W + Q_W;
	localparam int D_A  = T_W + 2;
	localparam int D_B  = Q_W + FRAC_BITS + 1;
	localparam int D_C  = PLANE_W + 2 * FRAC_BITS + 1;
	localparam int D_M  = (D_A > D_B) ? ((D_A > D_C) ? D_A : D_C) : ((D_B > D_C) ? D_B : D_C);
	localparam int D_W  = D_M + 1;

	tstate_t state_q, state_nxt;

	logic [ELEM_W-1:0]  omem [16];
	logic [15:0]        ovld_q;
	logic [ELEM_W-1:0]  oraw_s1;
	logic               ovld_s1;
	logic [3:0]         oaddr;
	logic signed [ELEM_W-1:0] odata;

	box_t               box_q;
	logic [2:0]         k_q;
	logic [1:0]         j_q;
	logic [1:0]         col_q;
	logic               half_q;
	logic               part_q;
	logic               prdv_s1;
	logic [1:0]         pj_s1;
	logic               vis_q;

	logic signed [PLANE_W-1:0] pl_q [4];
	logic signed [Q_W-1:0]     q_q [4];
	logic signed [T_W-1:0]     t_q [2];
	logic signed [D_W-1:0]     d_q;

	logic signed [MA_W-1:0]    mul_a;
	logic signed [MB_W-1:0]    mul_b;
	logic signed [P_W-1:0]     prod_s1;
	logic signed [ELEM_W-1:0]  cv;
	logic signed [Q_W-1:0]     qsel;
	logic signed [T_W-1:0]     pext, tmax;
	logic signed [D_W-1:0]     d_init;
	logic                      d_pos;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			T_IDLE:  if (start) state_nxt = T_PRD;
			T_PRD:   if (j_q == 2'd3) state_nxt = T_PCAP;
			T_PCAP:  state_nxt = T_QRD;
			T_QRD:   state_nxt = T_QMUL;
			T_QMUL:  state_nxt = T_QACC;
			T_QACC:  state_nxt = (j_q == 2'd2 && col_q == 2'd3) ? T_CINIT : T_QRD;
			T_CINIT: state_nxt = T_CMUL;
			T_CMUL:  state_nxt = T_CACC;
			T_CACC:  state_nxt = (part_q && half_q) ? T_CSUM : T_CMUL;
			T_CSUM:  state_nxt = (col_q == 2'd2) ? T_CDEC : T_CMUL;
			T_CDEC:  state_nxt = (d_pos && k_q != 3'(PLANE_COUNT - 1)) ? T_PRD : T_DONE;
			T_DONE:  if (res_ready) state_nxt = T_IDLE;
			default: state_nxt = T_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		idle        = (state_q == T_IDLE);
		res_valid   = (state_q == T_DONE);
		res_visible = vis_q;
		pl_addr     = {k_q, j_q};
		oaddr       = {col_q, j_q};
	end

	// object memory
	always_ff @(posedge clk) begin
		if (obj_we) omem[obj_idx] <= obj_val;
		oraw_s1 <= omem[oaddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q  <= '0;
			ovld_s1 <= 1'b0;
		end else begin
			if (obj_we) ovld_q[obj_idx] <= 1'b1;
			ovld_s1 <= ovld_q[oaddr];
		end
	end

	assign odata = ovld_s1 ? signed'(oraw_s1) : '0;

	// shared multiplier operands
	always_comb begin
		unique case (col_q)
			2'd0:    cv = half_q ? box_q.max_x : box_q.min_x;
			2'd1:    cv = half_q ? box_q.max_y : box_q.min_y;
			default: cv = half_q ? box_q.max_z : box_q.min_z;
		endcase
		qsel = q_q[col_q];
		if (state_q == T_CMUL) begin
			mul_a = MA_W'(cv);
			mul_b = part_q ? MB_W'(signed'(qsel[Q_W-1:Q_SPLIT]))
			               : signed'({1'b0, qsel[Q_SPLIT-1:0]});
		end else begin
			mul_a = pl_q[j_q];
			mul_b = MB_W'(odata);
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	// sums for the best corner along one axis, the start value of the plane sum and its sign test
	always_comb begin
		pext   = T_W'(prod_s1);
		tmax   = (t_q[0] > t_q[1]) ? t_q[0] : t_q[1];
		d_init = (D_W'(pl_q[3]) <<< (2 * FRAC_BITS)) + (D_W'(q_q[3]) <<< FRAC_BITS);
		d_pos  = (d_q != '0) && !d_q[D_W-1];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			k_q     <= '0;
			j_q     <= '0;
			col_q   <= '0;
			half_q  <= 1'b0;
			part_q  <= 1'b0;
			prdv_s1 <= 1'b0;
			vis_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			prdv_s1 <= (state_q == T_PRD);
			unique case (state_q)
				T_IDLE: begin
					k_q <= '0;
					j_q <= '0;
				end
				T_PRD: j_q <= j_q + 2'd1;
				T_PCAP: begin
					j_q   <= '0;
					col_q <= '0;
				end
				T_QACC: begin
					if (j_q == 2'd2) begin
						j_q   <= '0;
						col_q <= col_q + 2'd1;
					end else begin
						j_q <= j_q + 2'd1;
					end
				end
				T_CINIT: begin
					col_q  <= '0;
					half_q <= 1'b0;
					part_q <= 1'b0;
				end
				T_CACC: begin
					part_q <= ~part_q;
					if (part_q) half_q <= ~half_q;
				end
				T_CSUM: col_q <= col_q + 2'd1;
				T_CDEC: begin
					j_q   <= '0;
					k_q   <= k_q + 3'd1;
					vis_q <= d_pos;
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		pj_s1 <= j_q;
		if (prdv_s1) pl_q[pj_s1] <= pl_data;
		if (state_q == T_IDLE && start) box_q <= box;
		if (state_q == T_PCAP) begin
			for (int i = 0; i < 4; i++) q_q[i] <= '0;
		end
		if (state_q == T_QACC) q_q[col_q] <= q_q[col_q] + Q_W'(prod_s1);
		if (state_q == T_CINIT) d_q <= d_init;
		if (state_q == T_CINIT || state_q == T_CSUM) begin
			t_q[0] <= '0;
			t_q[1] <= '0;
		end
		if (state_q == T_CACC) t_q[half_q] <= t_q[half_q] + (part_q ? (pext <<< Q_SPLIT) : pext);
		if (state_q == T_CSUM) d_q <= d_q + D_W'(tmax);
	end

endmodule

@@ sv/frustum_box_cull.sv @@
// ----------------------------------------------------------------------------
// frustum_box_cull
// View frustum culling of an axis aligned box in exact fixed point.
// ----------------------------------------------------------------------------
// A command word writes one view or object matrix element or tests a box.
// A view element write rebuilds the six planes of that column through the
// view and plane memories. A box test walks the planes one after another
// through a single shared 33 x 35 bit multiplier and stops early when a
// plane rejects the box. The verdict sits in an output register, so the next
// command word is taken while it waits. Command code 3 is taken and ignored.
`timescale 1ns / 1ps

module frustum_box_cull import fcb_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	fcb_item_if.sink    item,
	fcb_result_if.source result
);

	logic                       acc;
	cmd_t                       cmd;
	logic                       pl_idle, ts_idle;
	logic [PL_ADDR_W-1:0]       pl_addr;
	logic signed [PLANE_W-1:0]  pl_data;
	logic                       res_valid, res_visible, res_ready;
	box_t                       box;
	logic                       out_valid_q, visible_q;

	// command dispatch
	always_comb begin
		item.ready = pl_idle && ts_idle;
		acc        = item.valid && item.ready;
		cmd        = cmd_t'(item.command);
		box.min_x  = item.box_min_x;
		box.min_y  = item.box_min_y;
		box.min_z  = item.box_min_z;
		box.max_x  = item.box_max_x;
		box.max_y  = item.box_max_y;
		box.max_z  = item.box_max_z;
	end

	fcb_plane_unit u_plane (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (acc && cmd == CMD_VIEW),
		.wr_idx  (item.elem_index),
		.wr_val  (item.elem_value),
		.rd_addr (pl_addr),
		.rd_data (pl_data),
		.idle    (pl_idle)
	);

	fcb_test_unit #(.FRAC_BITS(FRAC_BITS)) u_test (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (acc && cmd == CMD_TEST),
		.box         (box),
		.obj_we      (acc && cmd == CMD_OBJ),
		.obj_idx     (item.elem_index),
		.obj_val     (item.elem_value),
		.pl_addr     (pl_addr),
		.pl_data     (pl_data),
		.res_valid   (res_valid),
		.res_visible (res_visible),
		.res_ready   (res_ready),
		.idle        (ts_idle)
	);

	// output register
	assign res_ready = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) visible_q <= res_visible;
	end

	assign result.valid   = out_valid_q;
	assign result.visible = visible_q;

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for frustum_box_cull: matrix loads and box tests are
// mirrored by an exact wide-integer cull predictor and every verdict word is
// compared against it, under random sender and receiver idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import fcb_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC;

	logic clk;
	logic arst_n;

	fcb_item_if   item ();
	fcb_result_if result ();

	frustum_box_cull dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item.sink),
		.result (result.source)
	);

	// predictor state
	logic signed [31:0] view_m [16];
	logic signed [31:0] obj_m  [16];
	logic signed [32:0] planes [24];
	bit                 verdict_q [$];

	int send_idle;
	int recv_idle;
	int hold_cycles;
	int mismatches;
	int words_sent;
	int verdicts_seen;
	int visible_seen;

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// rebuild the six planes from the view matrix
	function automatic void derive_planes();
		int                 rows [6];
		bit                 adds [6];
		logic signed [32:0] w;
		logic signed [32:0] e;
		rows = '{0, 0, 1, 1, 2, 2};
		adds = '{1, 0, 0, 1, 1, 0};
		for (int k = 0; k < 6; k++) begin
			for (int c = 0; c < 4; c++) begin
				w = view_m[c*4+3];
				e = view_m[c*4+rows[k]];
				planes[k*4+c] = adds[k] ? w + e : w - e;
			end
		end
	endfunction

	// exact cull verdict for one box
	function automatic bit cull_verdict(box_t b);
		logic signed [127:0] pt [8][3];
		logic signed [127:0] cv [4];
		logic signed [127:0] m;
		logic signed [127:0] acc;
		logic signed [127:0] d;
		logic signed [127:0] pa, pb, pc, pd;
		bit                  hit;
		for (int n = 0; n < 8; n++) begin
			cv[0] = (n & 1) ? b.max_x : b.min_x;
			cv[1] = (n & 2) ? b.max_y : b.min_y;
			cv[2] = (n & 4) ? b.max_z : b.min_z;
			cv[3] = ONE;
			for (int r = 0; r < 3; r++) begin
				acc = 0;
				for (int c = 0; c < 4; c++) begin
					m = obj_m[c*4+r];
					acc = acc + m * cv[c];
				end
				pt[n][r] = acc;
			end
		end
		for (int k = 0; k < 6; k++) begin
			pa = planes[k*4];
			pb = planes[k*4+1];
			pc = planes[k*4+2];
			pd = planes[k*4+3];
			pd = pd <<< (2 * FRAC);
			hit = 0;
			for (int n = 0; n < 8; n++) begin
				d = pd + pt[n][0] * pa + pt[n][1] * pb + pt[n][2] * pc;
				if (d > 0)
					hit = 1;
			end
			if (!hit)
				return 0;
		end
		return 1;
	endfunction

	// send one command word and update the predictor on acceptance
	task automatic send_word(cmd_t c, logic [3:0] idx, logic signed [31:0] v, box_t b);
		while ($urandom_range(99) < send_idle) begin
			@(negedge clk);
			item.valid = 1'b0;
		end
		@(negedge clk);
		item.valid      = 1'b1;
		item.command    = c;
		item.elem_index = idx;
		item.elem_value = v;
		item.box_min_x  = b.min_x;
		item.box_min_y  = b.min_y;
		item.box_min_z  = b.min_z;
		item.box_max_x  = b.max_x;
		item.box_max_y  = b.max_y;
		item.box_max_z  = b.max_z;
		do @(posedge clk); while (!item.ready);
		words_sent++;
		case (c)
			CMD_VIEW: begin
				view_m[idx] = v;
				derive_planes();
			end
			CMD_OBJ: obj_m[idx] = v;
			CMD_TEST: verdict_q.push_back(cull_verdict(b));
			default: ;
		endcase
	endtask

	task automatic write_view(int idx, logic signed [31:0] v);
		send_word(CMD_VIEW, idx[3:0], v, '0);
	endtask

	task automatic write_obj(int idx, logic signed [31:0] v);
		send_word(CMD_OBJ, idx[3:0], v, '0);
	endtask

	task automatic test_box(logic signed [31:0] x0, y0, z0, x1, y1, z1);
		box_t b;
		b = '{x0, y0, z0, x1, y1, z1};
		send_word(CMD_TEST, 4'd0, 32'sd0, b);
	endtask

	// value mostly within a few units, sometimes any 32 bit pattern
	function automatic logic signed [31:0] rand_val();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom_range(0, 8 * ONE)) - 4 * ONE;
			2: return $signed($urandom_range(0, 2 * ONE)) - ONE;
			default: return $urandom_range(1) ? ONE : -ONE;
		endcase
	endfunction

	// receiver: random stalls plus a long counted hold-off
	always @(negedge clk) begin
		if (!arst_n)
			result.ready = 1'b0;
		else if (hold_cycles > 0) begin
			hold_cycles--;
			result.ready = 1'b0;
		end else
			result.ready = ($urandom_range(99) >= recv_idle);
	end

	// verdict checker
	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready) begin
			verdicts_seen++;
			if (result.visible)
				visible_seen++;
			if (verdict_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected verdict word: visible=%0b", result.visible);
			end else begin
				bit exp_vis;
				exp_vis = verdict_q.pop_front();
				if (exp_vis !== result.visible) begin
					mismatches++;
					if (mismatches <= 10)
						$display("visible mismatch: expected %0b actual %0b",
							exp_vis, result.visible);
				end
			end
		end
	end

	// nothing derived yet, then the unused code
	task automatic run_reset_state();
		test_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
		send_word(CMD_NONE, 4'hf, 32'sh7fffffff, '1);
		test_box(0, 0, 0, 0, 0, 0);
	endtask

	// identity matrices, boxes inside, outside, inverted and at the extremes
	task automatic run_identity();
		for (int i = 0; i < 4; i++) begin
			write_view(i * 5, ONE);
			write_obj(i * 5, ONE);
		end
		test_box(-ONE / 2, -ONE / 2, -ONE / 2, ONE / 2, ONE / 2, ONE / 2);
		test_box(3 * ONE, 3 * ONE, 3 * ONE, 4 * ONE, 4 * ONE, 4 * ONE);
		test_box(ONE / 2, ONE / 2, ONE / 2, -ONE / 2, -ONE / 2, -ONE / 2);
		test_box(32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		test_box(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh80000000, 32'sh80000000, 32'sh80000000);
		write_obj(3, 32'sh80000000);
		write_obj(12, 32'sh7fffffff);
		test_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
		write_obj(3, 0);
		write_obj(12, 0);
	endtask

	// zero normals, where only the constant term decides, then an extreme z normal
	task automatic run_degenerate();
		for (int i = 0; i < 16; i++)
			write_view(i, 0);
		write_view(15, ONE);
		test_box(5 * ONE, -7 * ONE, 2 * ONE, 6 * ONE, -6 * ONE, 3 * ONE);
		write_view(15, -ONE);
		test_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
		write_view(15, 32'sh80000000);
		write_view(11, 32'sh7fffffff);
		test_box(0, 0, 0, ONE, ONE, ONE);
	endtask

	// random mix of loads, tests and unused code words
	task automatic run_random(int n);
		int   pick;
		box_t b;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 25)
				write_view($urandom_range(15), rand_val());
			else if (pick < 40)
				write_obj($urandom_range(15), rand_val());
			else if (pick < 95) begin
				b = '{rand_val(), rand_val(), rand_val(), rand_val(), rand_val(), rand_val()};
				send_word(CMD_TEST, 4'($urandom), $urandom, b);
			end else
				send_word(CMD_NONE, 4'($urandom), $urandom, '{$urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom});
		end
	endtask

	// receiver holds off long enough for the input to back up
	task automatic run_backpressure();
		hold_cycles = 3000;
		for (int i = 0; i < 8; i++)
			test_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
	endtask

	initial begin
		item.valid      = 1'b0;
		item.command    = CMD_NONE;
		item.elem_index = '0;
		item.elem_value = '0;
		item.box_min_x  = '0;
		item.box_min_y  = '0;
		item.box_min_z  = '0;
		item.box_max_x  = '0;
		item.box_max_y  = '0;
		item.box_max_z  = '0;
		result.ready    = 1'b0;
		for (int i = 0; i < 16; i++) begin
			view_m[i] = '0;
			obj_m[i]  = '0;
		end
		for (int i = 0; i < 24; i++)
			planes[i] = '0;
		send_idle = 29;
		recv_idle = 73;
		hold_cycles = 0;
		mismatches = 0;
		words_sent = 0;
		verdicts_seen = 0;
		visible_seen = 0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_reset_state();
		run_identity();
		run_degenerate();
		run_identity();
		run_backpressure();
		run_random(195);
		send_idle = 73;
		recv_idle = 29;
		run_random(195);
		send_idle = 0;
		recv_idle = 0;
		run_random(195);

		@(negedge clk);
		item.valid = 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (500) @(posedge clk);

		$display("covered %0d command words, %0d verdicts checked (%0d visible)",
			words_sent, verdicts_seen, visible_seen);
		$display("view/object loads, unused code, degenerate planes and long stall included");
		if (mismatches == 0 && verdict_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else begin
			$display("%0d mismatches, %0d verdicts missing", mismatches, verdict_q.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// watchdog
	initial begin
		#30ms;
		$display("timeout with %0d verdicts outstanding", verdict_q.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
